FILE: hdl/bis_pkg.sv
// shared constants, types and helpers for the bilinear image sampler
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

  // field widths fixed by the interface
  localparam int CFG_W      = 9;
  localparam int COORD_W    = 17;
  localparam int CU_W       = COORD_W - 1;
  localparam int CHAN_W     = 8;
  localparam int OUT_W      = 16;
  localparam int PIX_W      = 32;
  localparam int LIM_W      = 13;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // default sizes
  localparam int DEF_MAX_WIDTH     = 256;
  localparam int DEF_MAX_HEIGHT    = 256;
  localparam int DEF_FRACTION_BITS = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // transaction kinds
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register index, taken from address bit 2
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // image size in use
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

  // queue entry: op, u0, u1, v0, v1, fu, fv, pixel word (lowest first)
  function automatic int entry_w(input int xb, input int yb, input int fb);
    return 1 + 2 * xb + 2 * yb + 2 * fb + PIX_W;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bis_queue.sv
// short fifo between the front and back parts of the sampler
`timescale 1ns / 1ps
`default_nettype none

module bis_queue
  import bis_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      count_r;

  assign full     = (count_r == (PW + 1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (PW + 1)'(1);
        2'b01:   count_r <= count_r - (PW + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");

endmodule

`default_nettype wire

FILE: hdl/bis_front.sv
// front part: accepts transactions, clamps coordinates and finds neighbours
`timescale 1ns / 1ps
`default_nettype none

module bis_front
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // pixel_x, pixel_y, write_red, write_green, write_blue, write_alpha,
  // coord_u, coord_v, zero fill
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  // op
  input  wire logic [0:0]           in_tuser,
  input  wire logic                 q_full,
  output logic                      q_push,
  output logic [entry_w($clog2(MAX_WIDTH), $clog2(MAX_HEIGHT), FRACTION_BITS)-1:0] q_data
);

  localparam int XB   = $clog2(MAX_WIDTH);
  localparam int YB   = $clog2(MAX_HEIGHT);
  localparam int F    = FRACTION_BITS;
  localparam int TOPW = (CFG_W + F > CU_W) ? CFG_W + F : CU_W;
  localparam int XCW  = ((XB > CFG_W) ? XB : CFG_W) + 1;
  localparam int YCW  = ((YB > CFG_W) ? YB : CFG_W) + 1;
  localparam logic [LIM_W-1:0] MAX_W_L = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] MAX_H_L = LIM_W'(MAX_HEIGHT);

  // clamp a signed coordinate to [0, (size-1) << F]
  function automatic logic [CU_W-1:0] clamp_coord(input logic [COORD_W-1:0] c,
                                                  input logic [CFG_W-1:0]   s);
    logic [TOPW-1:0] top;
    logic [TOPW-1:0] mag;
    top = TOPW'(s - CFG_W'(1)) << F;
    mag = TOPW'(c[COORD_W-2:0]);
    if (c[COORD_W-1]) return '0;
    else if (mag > top) return CU_W'(top);
    else return CU_W'(mag);
  endfunction

  logic                op;
  logic [CHAN_W-1:0]   pixel_x;
  logic [CHAN_W-1:0]   pixel_y;
  logic [PIX_W-1:0]    pixel_word;
  logic [COORD_W-1:0]  coord_u;
  logic [COORD_W-1:0]  coord_v;
  logic [CU_W-1:0]     cu;
  logic [CU_W-1:0]     cv;
  logic [XB-1:0]       u0;
  logic [XB-1:0]       u1;
  logic [YB-1:0]       v0;
  logic [YB-1:0]       v1;
  logic [F-1:0]        fu;
  logic [F-1:0]        fv;
  logic [XCW-1:0]      u0_inc;
  logic [YCW-1:0]      v0_inc;
  logic                wr_in_range;
  logic                keep;

  // field unpacking
  assign op         = in_tuser[0];
  assign pixel_x    = in_tdata[7:0];
  assign pixel_y    = in_tdata[15:8];
  assign pixel_word = in_tdata[47:16];
  assign coord_u    = in_tdata[64:48];
  assign coord_v    = in_tdata[81:65];

  // clamped coordinates and the four neighbours
  always_comb begin
    cu     = clamp_coord(coord_u, cfg.width);
    cv     = clamp_coord(coord_v, cfg.height);
    u0     = XB'(cu >> F);
    v0     = YB'(cv >> F);
    fu     = F'(cu);
    fv     = F'(cv);
    u0_inc = XCW'(u0) + XCW'(1);
    v0_inc = YCW'(v0) + YCW'(1);
    if (u0_inc < XCW'(cfg.width)) u1 = XB'(u0_inc);
    else u1 = XB'(cfg.width - CFG_W'(1));
    if (v0_inc < YCW'(cfg.height)) v1 = YB'(v0_inc);
    else v1 = YB'(cfg.height - CFG_W'(1));
  end

  // classify: samples and in-range writes go on, other writes are dropped
  assign wr_in_range = (LIM_W'(pixel_x) < MAX_W_L) && (LIM_W'(pixel_y) < MAX_H_L);
  assign keep        = (op == OP_SAMPLE) || wr_in_range;
  assign in_tready   = !q_full;
  assign q_push      = in_tvalid && !q_full && keep;

  // queue entry, writes carry their pixel position in u0 and v0
  always_comb begin
    if (op == OP_SAMPLE) begin
      q_data = {PIX_W'(0), fv, fu, v1, v0, u1, u0, OP_SAMPLE};
    end else begin
      q_data = {pixel_word, F'(0), F'(0), YB'(0), YB'(pixel_y),
                XB'(0), XB'(pixel_x), OP_WRITE};
    end
  end

  a_base_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && op == OP_SAMPLE) |->
      (XCW'(u0) < XCW'(cfg.width)) && (YCW'(v0) < YCW'(cfg.height)))
    else $error("sample base pixel outside image");

  a_far_neighbour: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && op == OP_SAMPLE) |->
      ((u1 == u0) || (XCW'(u1) == u0_inc)) && ((v1 == v0) || (YCW'(v1) == v0_inc)))
    else $error("far neighbour not adjacent or clamped");

endmodule

`default_nettype wire

FILE: hdl/bis_back.sv
// back part: banked pixel store, row and column interpolation, output register
`timescale 1ns / 1ps
`default_nettype none

module bis_back
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire logic [entry_w($clog2(MAX_WIDTH), $clog2(MAX_HEIGHT), FRACTION_BITS)-1:0] q_data,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // sample_red, sample_green, sample_blue, sample_alpha
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);
  localparam int F     = FRACTION_BITS;
  localparam int XHB   = (XB > 1) ? XB - 1 : 1;
  localparam int YHB   = (YB > 1) ? YB - 1 : 1;
  localparam int BAW   = XHB + YHB;
  localparam int BANK_DEPTH = 1 << BAW;
  localparam int RW    = CHAN_W + F;
  localparam int RSW   = CHAN_W + F + 2;
  localparam int CSW   = RW + F + 2;
  localparam logic [F:0] ONE = {1'b1, F'(0)};

  // entry fields
  logic              h_op;
  logic [XB-1:0]     h_u0;
  logic [XB-1:0]     h_u1;
  logic [YB-1:0]     h_v0;
  logic [YB-1:0]     h_v1;
  logic [F-1:0]      h_fu;
  logic [F-1:0]      h_fv;
  logic [PIX_W-1:0]  h_word;

  assign {h_word, h_fv, h_fu, h_v1, h_v0, h_u1, h_u0, h_op} = q_data;

  logic pipe_en;
  logic is_sample;

  // whole pipeline moves unless the output register holds an untaken result
  assign pipe_en   = !out_tvalid || out_tready;
  assign q_pop     = pipe_en && !q_empty;
  assign is_sample = (h_op == OP_SAMPLE);

  // bank addresses, bank index is {y parity, x parity}
  logic [BAW-1:0]   bank_addr [4];
  logic [3:0]       bank_wr;
  logic [PIX_W-1:0] bank_rd_r [4];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [XB-1:0] xs;
      logic [YB-1:0] ys;
      xs = (h_u0[0] == b[0]) ? h_u0 : h_u1;
      ys = (h_v0[0] == b[1]) ? h_v0 : h_v1;
      bank_addr[b] = {YHB'(ys >> 1), XHB'(xs >> 1)};
      bank_wr[b]   = q_pop && !is_sample && ({h_v0[0], h_u0[0]} == 2'(b));
    end
  end

  // four single-port banks
  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [PIX_W-1:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (bank_wr[gb]) mem[bank_addr[gb]] <= h_word;
      if (pipe_en) bank_rd_r[gb] <= mem[bank_addr[gb]];
    end
  end

  // stage 1: fetched words and neighbour parities
  logic         s1_valid_r;
  logic [3:0]   s1_par_r;
  logic [F-1:0] s1_fu_r;
  logic [F-1:0] s1_fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= q_pop && is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_par_r <= {h_v1[0], h_v0[0], h_u1[0], h_u0[0]};
      s1_fu_r  <= h_fu;
      s1_fv_r  <= h_fv;
    end
  end

  // row interpolation along u, exact
  logic [PIX_W-1:0] p00;
  logic [PIX_W-1:0] p10;
  logic [PIX_W-1:0] p01;
  logic [PIX_W-1:0] p11;
  logic [RW-1:0]    row0_nxt [4];
  logic [RW-1:0]    row1_nxt [4];

  always_comb begin
    logic [F:0]   wu;
    logic [RSW-1:0] s0;
    logic [RSW-1:0] s1;
    p00 = bank_rd_r[{s1_par_r[2], s1_par_r[0]}];
    p10 = bank_rd_r[{s1_par_r[2], s1_par_r[1]}];
    p01 = bank_rd_r[{s1_par_r[3], s1_par_r[0]}];
    p11 = bank_rd_r[{s1_par_r[3], s1_par_r[1]}];
    wu  = ONE - {1'b0, s1_fu_r};
    for (int k = 0; k < 4; k++) begin
      s0 = RSW'(p00[CHAN_W*k +: CHAN_W]) * RSW'(wu)
         + RSW'(p10[CHAN_W*k +: CHAN_W]) * RSW'(s1_fu_r);
      s1 = RSW'(p01[CHAN_W*k +: CHAN_W]) * RSW'(wu)
         + RSW'(p11[CHAN_W*k +: CHAN_W]) * RSW'(s1_fu_r);
      row0_nxt[k] = RW'(s0);
      row1_nxt[k] = RW'(s1);
    end
  end

  // stage 2: row values
  logic          s2_valid_r;
  logic [RW-1:0] s2_row0_r [4];
  logic [RW-1:0] s2_row1_r [4];
  logic [F-1:0]  s2_fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_row0_r <= row0_nxt;
      s2_row1_r <= row1_nxt;
      s2_fv_r   <= s1_fv_r;
    end
  end

  // column interpolation along v, floored
  logic [RW-1:0] col_nxt [4];

  always_comb begin
    logic [F:0]     wv;
    logic [CSW-1:0] sc;
    wv = ONE - {1'b0, s2_fv_r};
    for (int k = 0; k < 4; k++) begin
      sc = CSW'(s2_row0_r[k]) * CSW'(wv) + CSW'(s2_row1_r[k]) * CSW'(s2_fv_r);
      col_nxt[k] = RW'(sc >> F);
    end
  end

  // stage 3: output register
  logic          out_valid_r;
  logic [RW-1:0] out_col_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) out_col_r <= col_nxt;
  end

  assign out_tvalid = out_valid_r;

  // rescale to 8 fraction bits
  for (genvar gk = 0; gk < 4; gk++) begin : g_scale
    if (F >= 8) begin : g_down
      assign out_tdata[OUT_W*gk +: OUT_W] = OUT_W'(out_col_r[gk] >> (F - 8));
    end else begin : g_up
      assign out_tdata[OUT_W*gk +: OUT_W] = OUT_W'(out_col_r[gk]) << (8 - F);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bilinear_image_sampler.sv
// top level of the bilinear image sampler: register port and part wiring
`timescale 1ns / 1ps
`default_nettype none

// Bilinear RGBA8 image sampler with clamp-to-edge addressing. A transaction
// with tuser 0 writes one pixel; one with tuser 1 samples at signed fixed-point
// coordinates and returns four 8.8 channels. The block takes one transaction
// per clock while its queue is not full. A sample passes through the queue,
// which is written at the accepting edge, then the bank read, the row
// interpolation and the column interpolation into the output register. The
// pixel store is four single-port banks split by x and y parity, so the four
// neighbours of a sample are one read in each bank in the same cycle, and a
// write uses one bank. Reading a pixel that was never written returns an
// undefined value; the store has no clearing pass after reset. The image size
// registers may only be changed while no transaction is in flight.

module bilinear_image_sampler
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // pixel_x, pixel_y, write_red, write_green, write_blue, write_alpha,
  // coord_u, coord_v, zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  wire logic [0:0]            in_tuser,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // sample_red, sample_green, sample_blue, sample_alpha
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // register port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int EW = entry_w(XB, YB, FRACTION_BITS);
  localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

  // zero reads as one, values above the maximum saturate
  function automatic logic [CFG_W-1:0] fit_size(input logic [CFG_W-1:0] v,
                                                input logic [LIM_W-1:0] mx);
    logic [CFG_W-1:0] s;
    s = (v == '0) ? CFG_W'(1) : v;
    if (LIM_W'(s) > mx) s = CFG_W'(mx);
    return s;
  endfunction

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             cfg_wr;
  cfg_t             cfg;

  // register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_IMAGE_WIDTH:  width_r  <= fit_size(cfg_pwdata[CFG_W-1:0], LIM_W'(MAX_WIDTH));
        REG_IMAGE_HEIGHT: height_r <= fit_size(cfg_pwdata[CFG_W-1:0], LIM_W'(MAX_HEIGHT));
        default:          width_r  <= width_r;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_paddr[2])
      REG_IMAGE_WIDTH:  cfg_prdata = APB_DATA_W'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = APB_DATA_W'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [EW-1:0] q_in;
  logic [EW-1:0] q_out;

  bis_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  bis_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  bis_back #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: verif/bilinear_image_sampler_tb.sv
// testbench for the bilinear image sampler: stimulus, sample predictor and result checks
`timescale 1ns / 1ps

module bilinear_image_sampler_tb
  import bis_pkg::*;
();

  localparam int MAX_W      = DEF_MAX_WIDTH;
  localparam int MAX_H      = DEF_MAX_HEIGHT;
  localparam int FRAC       = DEF_FRACTION_BITS;
  localparam int ONE        = 1 << FRAC;
  localparam int DRAIN_WAIT = 8;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_LEN   = 200;

  // one result transaction, red in the lowest bits
  typedef struct packed {
    logic [OUT_W-1:0] alpha;
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] red;
  } sample_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // image copy and size registers as the block should hold them
  logic [PIX_W-1:0] image_copy [0:MAX_W*MAX_H-1];
  bit               pixel_loaded [0:MAX_W*MAX_H-1];
  int               img_w;
  int               img_h;

  sample_t expected_samples[$];

  int fail_count;
  int n_writes;
  int n_samples;
  int n_results;
  int n_reg_writes;
  int n_sizes;
  int send_idle_pct;
  int stall_pct;
  int hold_len;
  int hold_seq;
  int hold_seen;
  int stall_left;
  int quiet_cycles;

  bilinear_image_sampler u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    // pixel_x, pixel_y, write_red, write_green, write_blue, write_alpha,
    // coord_u, coord_v, zero fill
    .in_tdata    (in_tdata),
    // op
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    // sample_red, sample_green, sample_blue, sample_alpha
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // size register value as the block takes it
  function automatic int fit_size(input logic [CFG_W-1:0] raw, input int limit);
    int s;
    s = raw;
    if (s == 0) s = 1;
    if (s > limit) s = limit;
    return s;
  endfunction

  // clamp one coordinate and split it into near index, far index and fraction
  function automatic void axis_split(input logic [COORD_W-1:0] c, input int size,
                                     output int i0, output int i1, output int fr);
    int top;
    int mag;
    top = (size - 1) << FRAC;
    mag = c[COORD_W-1] ? 0 : int'(c[COORD_W-2:0]);
    if (mag > top) mag = top;
    i0 = mag >> FRAC;
    fr = mag & (ONE - 1);
    i1 = (i0 + 1 < size) ? i0 + 1 : size - 1;
  endfunction

  // all four neighbors of a sample hold written pixels
  function automatic bit neighbors_loaded(input logic [COORD_W-1:0] cu,
                                          input logic [COORD_W-1:0] cv);
    int u0, u1, v0, v1, fu, fv;
    axis_split(cu, img_w, u0, u1, fu);
    axis_split(cv, img_h, v0, v1, fv);
    return pixel_loaded[v0*MAX_W+u0] && pixel_loaded[v0*MAX_W+u1] &&
           pixel_loaded[v1*MAX_W+u0] && pixel_loaded[v1*MAX_W+u1];
  endfunction

  // bilinear blend of the four neighbors, u step exact, v step floored
  function automatic sample_t interpolate_sample(input logic [COORD_W-1:0] cu,
                                                 input logic [COORD_W-1:0] cv);
    int u0, u1, v0, v1, fu, fv;
    logic [PIX_W-1:0] p00, p10, p01, p11;
    longint row0, row1, blend;
    logic [OUT_DATA_W-1:0] packed_res;
    axis_split(cu, img_w, u0, u1, fu);
    axis_split(cv, img_h, v0, v1, fv);
    p00 = image_copy[v0*MAX_W+u0];
    p10 = image_copy[v0*MAX_W+u1];
    p01 = image_copy[v1*MAX_W+u0];
    p11 = image_copy[v1*MAX_W+u1];
    packed_res = '0;
    for (int k = 0; k < 4; k++) begin
      row0 = longint'(p00[8*k +: 8]) * (ONE - fu) + longint'(p10[8*k +: 8]) * fu;
      row1 = longint'(p01[8*k +: 8]) * (ONE - fu) + longint'(p11[8*k +: 8]) * fu;
      blend = (row0 * (ONE - fv) + row1 * fv) >> FRAC;
      if (FRAC >= 8) blend = blend >> (FRAC - 8);
      else blend = blend << (8 - FRAC);
      packed_res[OUT_W*k +: OUT_W] = blend[OUT_W-1:0];
    end
    return sample_t'(packed_res);
  endfunction

  // coordinate inside a loaded patch, any fraction
  function automatic logic [COORD_W-1:0] patch_axis(input int p, input int pw);
    int hi;
    hi = (pw > 2) ? pw - 2 : 0;
    return COORD_W'(((p + $urandom_range(hi, 0)) << FRAC) | $urandom_range(ONE - 1, 0));
  endfunction

  // coordinate drawn from a mix of raw, negative, past-edge and in-patch values
  function automatic logic [COORD_W-1:0] gen_axis(input int size, input int p,
                                                  input int pw);
    int pick;
    int top;
    pick = $urandom_range(9, 0);
    top = (size - 1) << FRAC;
    case (pick)
      0, 1: return COORD_W'($urandom);
      2: return {1'b1, (COORD_W-1)'($urandom)};
      3: return COORD_W'($urandom_range(65535, top));
      default: return patch_axis(p, pw);
    endcase
  endfunction

  // offer one transaction and wait until it is taken, then update the prediction
  task automatic send_item(input logic op, input logic [7:0] px, input logic [7:0] py,
                           input logic [PIX_W-1:0] rgba,
                           input logic [COORD_W-1:0] cu, input logic [COORD_W-1:0] cv);
    logic [IN_DATA_W-1:0] word;
    int idx;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    // unused fields carry junk that the block must ignore
    word = '0;
    word[7:0]   = (op == OP_WRITE) ? px : 8'($urandom);
    word[15:8]  = (op == OP_WRITE) ? py : 8'($urandom);
    word[47:16] = (op == OP_WRITE) ? rgba : 32'($urandom);
    word[64:48] = (op == OP_SAMPLE) ? cu : COORD_W'($urandom);
    word[81:65] = (op == OP_SAMPLE) ? cv : COORD_W'($urandom);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_WRITE) begin
      idx = int'(py) * MAX_W + int'(px);
      image_copy[idx] = rgba;
      pixel_loaded[idx] = 1'b1;
      n_writes++;
    end else begin
      expected_samples.push_back(interpolate_sample(cu, cv));
      n_samples++;
    end
  endtask

  task automatic write_pixel(input int px, input int py, input logic [PIX_W-1:0] rgba);
    send_item(OP_WRITE, 8'(px), 8'(py), rgba, '0, '0);
  endtask

  task automatic sample_at(input logic [COORD_W-1:0] cu, input logic [COORD_W-1:0] cv);
    send_item(OP_SAMPLE, 8'h00, 8'h00, '0, cu, cv);
  endtask

  // stop offering, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic reg_idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_idx == REG_IMAGE_WIDTH) img_w = fit_size(value, MAX_W);
    else img_h = fit_size(value, MAX_H);
    n_reg_writes++;
  endtask

  task automatic set_image_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    n_sizes++;
  endtask

  // loads a small block of pixels and returns how many were written
  task automatic load_patch(input int px, input int py, input int pw, input int ph,
                            output int count);
    count = 0;
    for (int y = py; y < py + ph; y++) begin
      for (int x = px; x < px + pw; x++) begin
        write_pixel(x, y, $urandom);
        count++;
      end
    end
  endtask

  // extremes of the fields, exact pixels, mid fractions, clamping on both sides
  task automatic test_directed_pixels();
    write_pixel(0, 0, 32'h0000_0000);
    write_pixel(1, 0, 32'hFFFF_FFFF);
    write_pixel(0, 1, 32'h00FF_00FF);
    write_pixel(1, 1, 32'hFF00_FF00);
    write_pixel(254, 254, 32'h1234_5678);
    write_pixel(255, 254, 32'hFFFF_FFFF);
    write_pixel(254, 255, 32'h0000_0000);
    write_pixel(255, 255, 32'h80C0_40FF);
    sample_at(17'h00000, 17'h00000);
    sample_at(17'h00080, 17'h00080);
    sample_at(17'h000FF, 17'h000FF);
    sample_at(17'h00001, 17'h000FF);
    sample_at(17'h0FFFF, 17'h0FFFF);
    sample_at(17'h0FF00, 17'h0FF00);
    sample_at(17'h0FE80, 17'h0FEFF);
    sample_at(17'h10000, 17'h1FFFF);
  endtask

  // zero and over-range size values, both single-pixel edges, tiny image
  task automatic test_size_registers();
    set_image_size(9'd0, 9'd511);
    sample_at(17'h0FFFF, 17'h00080);
    sample_at(17'h00040, 17'h1FFFF);
    set_image_size(9'd300, 9'd0);
    sample_at(17'h00080, 17'h0FFFF);
    sample_at(17'h1C000, 17'h00010);
    set_image_size(9'd2, 9'd2);
    sample_at(17'h0FFFF, 17'h00180);
    sample_at(17'h000C0, 17'h00033);
    set_image_size(9'd256, 9'd256);
    sample_at(17'h0FF7F, 17'h0FEC1);
  endtask

  // patches of written pixels, bursts of samples aimed at them, scattered writes
  task automatic test_random_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                   input int idle, input int stall, input int n_items);
    int done;
    int cnt;
    int px, py, pw, ph;
    logic [COORD_W-1:0] cu, cv;
    int tries;
    set_image_size(w, h);
    send_idle_pct = idle;
    stall_pct <= stall;
    done = 0;
    while (done < n_items) begin
      pw = (img_w < 2) ? 1 : $urandom_range((img_w < 4) ? img_w : 4, 2);
      ph = (img_h < 2) ? 1 : $urandom_range((img_h < 4) ? img_h : 4, 2);
      px = ($urandom_range(3, 0) == 0) ? img_w - pw : $urandom_range(img_w - pw, 0);
      py = ($urandom_range(3, 0) == 0) ? img_h - ph : $urandom_range(img_h - ph, 0);
      load_patch(px, py, pw, ph, cnt);
      done += cnt;
      repeat ($urandom_range(12, 4)) begin
        if ($urandom_range(9, 0) == 0) begin
          // overwrite anywhere, inside the patch or not
          if ($urandom_range(1, 0) == 0)
            write_pixel($urandom_range(255, 0), $urandom_range(255, 0), $urandom);
          else
            write_pixel(px + $urandom_range(pw - 1, 0), py + $urandom_range(ph - 1, 0),
                        $urandom);
        end else begin
          tries = 0;
          do begin
            cu = gen_axis(img_w, px, pw);
            cv = gen_axis(img_h, py, ph);
            tries++;
          end while (!neighbors_loaded(cu, cv) && tries < 40);
          if (!neighbors_loaded(cu, cv)) begin
            cu = patch_axis(px, pw);
            cv = patch_axis(py, ph);
          end
          sample_at(cu, cv);
        end
        done++;
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure_fill();
    set_image_size(9'd4, 9'd4);
    send_idle_pct = 0;
    stall_pct <= 0;
    begin
      int cnt;
      load_patch(0, 0, 4, 4, cnt);
    end
    hold_len <= HOLD_LEN;
    hold_seq <= hold_seq + 1;
    repeat (40) sample_at(patch_axis(0, 4) | 17'h00000, patch_axis(0, 4));
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    send_idle_pct = 0;
    stall_pct <= 30;
    repeat (3) begin
      repeat (10) sample_at(COORD_W'($urandom), COORD_W'($urandom));
      wait_idle();
    end
  endtask

  // stimulus sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_WRITE;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    img_w = fit_size(9'd256, MAX_W);
    img_h = fit_size(9'd256, MAX_H);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    hold_seq = 0;
    n_writes = 0;
    n_samples = 0;
    n_reg_writes = 0;
    n_sizes = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_pixels();
    test_size_registers();
    test_random_phase(9'd256, 9'd256, 0, 0, 110);
    test_random_phase(9'd1, 9'd256, 68, 0, 100);
    test_random_phase(9'd256, 9'd1, 0, 68, 100);
    test_random_phase(9'($urandom_range(8, 2)), 9'($urandom_range(8, 2)), 10, 10, 100);
    test_random_phase(9'($urandom), 9'($urandom), 0, 0, 80);
    test_backpressure_fill();
    test_drain_pause();
    test_random_phase(9'd3, 9'd2, 68, 68, 60);

    wait_idle();
    $display("covered %0d pixel writes and %0d samples over %0d image sizes",
             n_writes, n_samples, n_sizes);
    $display("%0d size register writes, %0d sample results compared",
             n_reg_writes, n_results);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_tready = 1'b0;
    hold_seen = 0;
    stall_left = 0;
  end

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      stall_left <= hold_len;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // result checker: each accepted transaction against the oldest expectation
  initial begin
    fail_count = 0;
    n_results = 0;
  end

  always @(posedge clk) begin
    sample_t want;
    sample_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        $error("sample result with no sample pending: %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_samples.pop_front();
        got  = sample_t'(out_tdata);
        n_results++;
        if (got.red !== want.red) begin
          $error("sample_red expected %h got %h", want.red, got.red);
          fail_count++;
        end
        if (got.green !== want.green) begin
          $error("sample_green expected %h got %h", want.green, got.green);
          fail_count++;
        end
        if (got.blue !== want.blue) begin
          $error("sample_blue expected %h got %h", want.blue, got.blue);
          fail_count++;
        end
        if (got.alpha !== want.alpha) begin
          $error("sample_alpha expected %h got %h", want.alpha, got.alpha);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any transaction ends the run
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d samples outstanding", expected_samples.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
